FILE: src/crbt_pkg.sv
// ----------------------------------------------------------------------------
// CoAP retransmit backoff timer package
// Shared widths, item kinds, message types and register map.
// ----------------------------------------------------------------------------
package crbt_pkg;

    // Acknowledgement timer width (17 to 32)
    localparam int ACK_TIMER_BITS = 24;

    localparam int ACK_BASE_BITS = 16;
    localparam int CLEANUP_BITS  = 16;
    localparam int MAX_RETX_BITS = 3;
    localparam int RETRY_BITS    = 4;

    // Widest backoff product: base wait shifted by the largest count
    localparam int BACKOFF_BITS = ACK_BASE_BITS + (1 << RETRY_BITS) - 1;
    localparam logic [BACKOFF_BITS-1:0] ACK_MAX =
        BACKOFF_BITS'((64'(1) << ACK_TIMER_BITS) - 64'(1));
    localparam logic [RETRY_BITS-1:0] RETRY_SAT = '1;

    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    localparam logic [ACK_BASE_BITS-1:0] ACK_TIMEOUT_RST = 16'd1000;
    localparam logic [MAX_RETX_BITS-1:0] MAX_RETX_RST    = 3'd3;
    localparam logic [CLEANUP_BITS-1:0]  CLEANUP_RST     = 16'd15000;

    typedef enum logic [1:0] {
        REG_ACK_TIMEOUT = 2'd0,
        REG_MAX_RETX    = 2'd1,
        REG_CLEANUP     = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_TRANSMIT = 2'd1,
        KIND_RESTART  = 2'd2,
        KIND_DONE     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TYPE_CON = 2'd0,
        TYPE_NON = 2'd1,
        TYPE_ACK = 2'd2,
        TYPE_RST = 2'd3
    } msg_type_t;

    typedef struct packed {
        logic xmit_timeout;
        logic not_responding;
        logic expect_reply;
        logic send_message;
    } result_t;

endpackage

FILE: src/coap_retransmit_backoff_timer_top.sv
// ----------------------------------------------------------------------------
// CoAP retransmit backoff timer
// Acknowledgement timer with exponential backoff and cleanup timer for one
// outgoing message; one result transaction per input transaction.
// Result path: an accepted input transaction is held in the input register,
// then the timer update writes the result register.
// Throughput: one item per cycle while the result stream is not stalled; the counter update is the loop.
// Reset: synchronous active-low aresetn stops both timers, clears the count
// and restores the configuration registers to 1000, 3 and 15000.
// ----------------------------------------------------------------------------
module coap_retransmit_backoff_timer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crbt_pkg::PADDR_BITS-1:0] paddr,
    input  logic [crbt_pkg::PDATA_BITS-1:0] pwdata,
    output logic [crbt_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [1:0] msg_type
    input  logic [1:0]                      s_tuser,  // [1:0] kind
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata   // [0] send_message,
                                                      // [1] expect_reply,
                                                      // [2] not_responding,
                                                      // [3] xmit_timeout
);
    import crbt_pkg::*;

    // configuration registers
    logic [ACK_BASE_BITS-1:0]  ack_timeout_reg;
    logic [MAX_RETX_BITS-1:0]  max_retx_reg;
    logic [CLEANUP_BITS-1:0]   cleanup_ticks_reg;

    // input register
    logic                      in_valid_reg, in_valid_next;
    kind_t                     in_kind_reg, in_kind_next;
    msg_type_t                 in_type_reg, in_type_next;

    // timer state
    logic [ACK_TIMER_BITS-1:0] ack_remaining_reg, ack_remaining_next;
    logic                      ack_running_reg, ack_running_next;
    logic [CLEANUP_BITS-1:0]   cleanup_remaining_reg, cleanup_remaining_next;
    logic                      cleanup_running_reg, cleanup_running_next;
    logic [RETRY_BITS-1:0]     retry_count_reg, retry_count_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_result_reg, out_result_next;

    logic                      advance;
    logic                      step;
    logic                      cfg_write;
    reg_idx_t                  cfg_idx;
    logic [RETRY_BITS-1:0]     count_inc;
    logic [BACKOFF_BITS-1:0]   backoff;
    logic [ACK_TIMER_BITS-1:0] backoff_sat;
    logic [ACK_TIMER_BITS-1:0] base_load;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_ACK_TIMEOUT: prdata = PDATA_BITS'(ack_timeout_reg);
            REG_MAX_RETX:    prdata = PDATA_BITS'(max_retx_reg);
            REG_CLEANUP:     prdata = PDATA_BITS'(cleanup_ticks_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg   <= ACK_TIMEOUT_RST;
            max_retx_reg      <= MAX_RETX_RST;
            cleanup_ticks_reg <= CLEANUP_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_ACK_TIMEOUT: ack_timeout_reg   <= pwdata[ACK_BASE_BITS-1:0];
                REG_MAX_RETX:    max_retx_reg      <= pwdata[MAX_RETX_BITS-1:0];
                REG_CLEANUP:     cleanup_ticks_reg <= pwdata[CLEANUP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees when empty or taken, and the
    // input register moves into it in that same cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_result_reg};

    always_comb begin
        in_valid_next = in_valid_reg;
        in_kind_next  = in_kind_reg;
        in_type_next  = in_type_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_kind_next  = kind_t'(s_tuser[1:0]);
            in_type_next  = msg_type_t'(s_tdata[1:0]);
        end
    end

    // backoff reload uses the count after increment; saturate at timer max
    assign count_inc   = (retry_count_reg == RETRY_SAT) ? RETRY_SAT
                                                        : retry_count_reg + 1'b1;
    assign backoff     = BACKOFF_BITS'(ack_timeout_reg) << count_inc;
    assign backoff_sat = (backoff > ACK_MAX) ? ACK_TIMER_BITS'(ACK_MAX)
                                             : ACK_TIMER_BITS'(backoff);
    assign base_load   = ACK_TIMER_BITS'(ack_timeout_reg);

    always_comb begin
        ack_remaining_next     = ack_remaining_reg;
        ack_running_next       = ack_running_reg;
        cleanup_remaining_next = cleanup_remaining_reg;
        cleanup_running_next   = cleanup_running_reg;
        retry_count_next       = retry_count_reg;
        out_valid_next         = out_valid_reg;
        out_result_next        = out_result_reg;

        if (advance) begin
            out_valid_next = in_valid_reg;
        end

        if (step) begin
            out_result_next = '0;
            unique case (in_kind_reg)
                KIND_TICK: begin
                    if (cleanup_running_reg) begin
                        if (cleanup_remaining_reg <= CLEANUP_BITS'(1)) begin
                            cleanup_remaining_next       = '0;
                            cleanup_running_next         = 1'b0;
                            out_result_next.xmit_timeout = 1'b1;
                        end else begin
                            cleanup_remaining_next = cleanup_remaining_reg - 1'b1;
                        end
                    end
                    if (ack_running_reg) begin
                        if (ack_remaining_reg <= ACK_TIMER_BITS'(1)) begin
                            retry_count_next = count_inc;
                            if (retry_count_reg <= RETRY_BITS'(max_retx_reg)) begin
                                // resend and back off
                                out_result_next.send_message = 1'b1;
                                ack_remaining_next           = backoff_sat;
                                ack_running_next             = 1'b1;
                            end else begin
                                // give up
                                ack_remaining_next             = '0;
                                ack_running_next               = 1'b0;
                                out_result_next.not_responding = 1'b1;
                                out_result_next.xmit_timeout   = 1'b1;
                            end
                        end else begin
                            ack_remaining_next = ack_remaining_reg - 1'b1;
                        end
                    end
                end
                KIND_TRANSMIT: begin
                    retry_count_next             = '0;
                    out_result_next.send_message = 1'b1;
                    if (in_type_reg == TYPE_ACK) begin
                        cleanup_remaining_next       = cleanup_ticks_reg;
                        cleanup_running_next         = 1'b1;
                        out_result_next.expect_reply = 1'b1;
                    end else if (in_type_reg == TYPE_CON) begin
                        ack_remaining_next           = base_load;
                        ack_running_next             = 1'b1;
                        out_result_next.expect_reply = 1'b1;
                    end
                end
                KIND_RESTART: begin
                    retry_count_next   = '0;
                    ack_remaining_next = base_load;
                    ack_running_next   = 1'b1;
                end
                KIND_DONE: begin
                    ack_running_next     = 1'b0;
                    cleanup_running_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            ack_remaining_reg     <= '0;
            ack_running_reg       <= 1'b0;
            cleanup_remaining_reg <= '0;
            cleanup_running_reg   <= 1'b0;
            retry_count_reg       <= '0;
        end else begin
            in_valid_reg          <= in_valid_next;
            out_valid_reg         <= out_valid_next;
            ack_remaining_reg     <= ack_remaining_next;
            ack_running_reg       <= ack_running_next;
            cleanup_remaining_reg <= cleanup_remaining_next;
            cleanup_running_reg   <= cleanup_running_next;
            retry_count_reg       <= retry_count_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        in_kind_reg    <= in_kind_next;
        in_type_reg    <= in_type_next;
        out_result_reg <= out_result_next;
    end

endmodule

FILE: src/crbt_checker.sv
// ----------------------------------------------------------------------------
// CoAP retransmit backoff timer port checker
// Port-level properties of the result stream and APB ready, bound to the top level.
// ----------------------------------------------------------------------------
module crbt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a reply is expected only with a send and without a timeout flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && !m_tdata[2] && !m_tdata[3])
        else $error("expect_reply without send or with a timeout flag");

    // give-up always reports a timeout and never a send
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[3] && !m_tdata[0])
        else $error("not_responding without xmit_timeout or with send");

    // padding bits stay clear and the config port is ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:4] == 4'b0 && pready)
        else $error("result padding set or config port not ready");

endmodule

bind coap_retransmit_backoff_timer_top crbt_checker u_crbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
